// File: rtl/tsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

  // Field widths of one timestamp.
  localparam int DayW    = 5;
  localparam int MonthW  = 4;
  localparam int YearW   = 14;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;

  // Result widths.
  localparam int DaysOutW = 22;

  // Internal widths.
  localparam int YW    = 15;  // year plus the shift, up to 16783
  localparam int DbmW  = 9;   // days before month, up to 334
  localparam int CentW = 8;   // year / 100, up to 167
  localparam int DnW   = 23;  // linear day number
  localparam int TodW  = 17;  // linear second of day, up to 115443
  localparam int RemW  = 17;  // normalised second of day, below 86400

  localparam int SecsPerDay  = 86400;
  localparam int SecsPerHour = 3600;
  localparam int SecsPerMin  = 60;
  localparam int DaysPerYear = 365;
  localparam int YearShift   = 400;

  // Reciprocals for division by a constant: x / d == (x * R) >> S over the used range.
  localparam int RecipHundred = 5243;   // / 100 for x below 2^15
  localparam int ShiftHundred = 19;
  localparam int RecipHour    = 37283;  // / 3600 for x below 86400
  localparam int ShiftHour    = 27;
  localparam int RecipMin     = 4370;   // / 60 for x below 3600
  localparam int ShiftMin     = 18;

  // Enables of the three stages of one timestamp front end.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } tsd_stage_en_t;

  // Days before the first of a month. Month zero counts as January, above twelve as December.
  function automatic logic [DbmW-1:0] days_before_month(input logic [MonthW-1:0] m);
    logic [DbmW-1:0] d;
    case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      default:    d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tsd_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsd_req_if import tsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DayW-1:0]    first_day;
  logic [MonthW-1:0]  first_month;
  logic [YearW-1:0]   first_year;
  logic [HourW-1:0]   first_hour;
  logic [MinuteW-1:0] first_minute;
  logic [SecondW-1:0] first_second;
  logic [DayW-1:0]    second_day;
  logic [MonthW-1:0]  second_month;
  logic [YearW-1:0]   second_year;
  logic [HourW-1:0]   second_hour;
  logic [MinuteW-1:0] second_minute;
  logic [SecondW-1:0] second_sec;

  modport source (
    output valid, first_day, first_month, first_year, first_hour, first_minute,
           first_second, second_day, second_month, second_year, second_hour,
           second_minute, second_sec,
    input  ready
  );

  modport sink (
    input  valid, first_day, first_month, first_year, first_hour, first_minute,
           first_second, second_day, second_month, second_year, second_hour,
           second_minute, second_sec,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/tsd_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsd_rsp_if import tsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DaysOutW-1:0] elapsed_days;
  logic [HourW-1:0]    elapsed_hours;
  logic [MinuteW-1:0]  elapsed_minutes;
  logic [SecondW-1:0]  elapsed_seconds;

  modport source (
    output valid, elapsed_days, elapsed_hours, elapsed_minutes, elapsed_seconds,
    input  ready
  );

  modport sink (
    input  valid, elapsed_days, elapsed_hours, elapsed_minutes, elapsed_seconds,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/tsd_stamp.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-stage front end that turns one timestamp into a linear day number
// and a linear second of day.
module tsd_stamp import tsd_pkg::*; (
  input  wire logic                clk,
  input  wire tsd_stage_en_t       en,
  input  wire logic [DayW-1:0]     day,
  input  wire logic [MonthW-1:0]   month,
  input  wire logic [YearW-1:0]    year,
  input  wire logic [HourW-1:0]    hour,
  input  wire logic [MinuteW-1:0]  minute,
  input  wire logic [SecondW-1:0]  second,
  output logic      [DnW-1:0]      day_num,
  output logic      [TodW-1:0]     tod
);

  localparam int ProdHW = YW + 13;

  // Stage 1.
  logic [YW-1:0]      y1, py1;
  logic [DbmW-1:0]    dbm1;
  logic               after_feb1;
  logic [DayW-1:0]    day1;
  logic [TodW-1:0]    tod1;
  // Stage 2.
  logic [YW-1:0]      y2, py2;
  logic [CentW-1:0]   yq2, pyq2;
  logic [DnW-1:0]     py365_2;
  logic [DbmW-1:0]    dbm2;
  logic               after_feb2;
  logic [DayW-1:0]    day2;
  logic [TodW-1:0]    tod2;

  logic [YW-1:0]      y_next;
  logic [ProdHW-1:0]  yprod, pyprod;
  logic               leap;

  assign y_next = YW'(year) + YW'(YearShift);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      y1         <= y_next;
      py1        <= y_next - YW'(1);
      dbm1       <= days_before_month(month);
      after_feb1 <= (month > MonthW'(2));
      day1       <= day;
      tod1       <= TodW'(hour) * TodW'(SecsPerHour) + TodW'(minute) * TodW'(SecsPerMin)
                    + TodW'(second);
    end
  end

  assign yprod  = ProdHW'(y1) * ProdHW'(RecipHundred);
  assign pyprod = ProdHW'(py1) * ProdHW'(RecipHundred);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      y2         <= y1;
      py2        <= py1;
      yq2        <= CentW'(yprod >> ShiftHundred);
      pyq2       <= CentW'(pyprod >> ShiftHundred);
      py365_2    <= DnW'(py1) * DnW'(DaysPerYear);
      dbm2       <= dbm1;
      after_feb2 <= after_feb1;
      day2       <= day1;
      tod2       <= tod1;
    end
  end

  // A year divisible by 100 is a leap year only when its century count is divisible by 4.
  assign leap = (y2[1:0] == 2'd0)
             && ((y2 != YW'(yq2) * YW'(100)) || (yq2[1:0] == 2'd0));

  always_ff @(posedge clk) begin
    if (en.s3) begin
      day_num <= py365_2 + DnW'(py2 >> 2) - DnW'(pyq2) + DnW'(pyq2 >> 2)
                 + DnW'(dbm2) + DnW'(after_feb2 && leap) + DnW'(day2);
      tod     <= tod2;
    end
  end

endmodule

`default_nettype wire

// File: rtl/timestamp_difference.sv
`timescale 1ns / 1ps
`default_nettype none

// Elapsed time between two Gregorian timestamps, given as whole days plus
// hours, minutes and seconds; the order of the two timestamps does not matter.
// The block is a ten-stage pipeline that takes one pair of timestamps per
// cycle while the output side does not stall. Each timestamp becomes a day
// number under the 4/100/400 leap rule; the two day numbers and seconds of
// day are subtracted, the seconds are normalised with a borrow or carry into
// the days, and the remainder is split by constant reciprocal multipliers.
// Every stage holds its own valid bit, so gaps in the pipeline close up
// while the output waits.
module timestamp_difference import tsd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  tsd_req_if.sink   req,
  tsd_rsp_if.source rsp
);

  localparam int NStage = 10;
  localparam int DW     = DnW + 1;   // signed day difference
  localparam int DnormW = DnW + 2;   // day difference after the borrow
  localparam int TW     = TodW + 1;  // signed second difference
  localparam int T2W    = TodW + 2;
  localparam int ProdHW = RemW + 16;
  localparam int MinW   = 12;        // seconds below one hour
  localparam int ProdMW = MinW + 13;

  logic [NStage:1] vld;
  logic [NStage:1] rdy;

  always_comb begin
    rdy[NStage] = !vld[NStage] || rsp.ready;
    for (int i = NStage - 1; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= req.valid;
      end
      for (int i = 2; i <= NStage; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign req.ready = rdy[1];

  // Stages 1 to 3: both timestamps to day number and second of day.
  tsd_stage_en_t    front_en;
  logic [DnW-1:0]   dn_a, dn_b;
  logic [TodW-1:0]  tod_a, tod_b;

  assign front_en = '{s1: rdy[1], s2: rdy[2], s3: rdy[3]};

  tsd_stamp u_stamp_a (
    .clk     (clk),
    .en      (front_en),
    .day     (req.first_day),
    .month   (req.first_month),
    .year    (req.first_year),
    .hour    (req.first_hour),
    .minute  (req.first_minute),
    .second  (req.first_second),
    .day_num (dn_a),
    .tod     (tod_a)
  );

  tsd_stamp u_stamp_b (
    .clk     (clk),
    .en      (front_en),
    .day     (req.second_day),
    .month   (req.second_month),
    .year    (req.second_year),
    .hour    (req.second_hour),
    .minute  (req.second_minute),
    .second  (req.second_sec),
    .day_num (dn_b),
    .tod     (tod_b)
  );

  // Stage 4: raw differences.
  logic signed [DW-1:0] ddiff4;
  logic signed [TW-1:0] tdiff4;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      ddiff4 <= signed'(DW'(dn_a)) - signed'(DW'(dn_b));
      tdiff4 <= signed'(TW'(tod_a)) - signed'(TW'(tod_b));
    end
  end

  // Stage 5: bring the second difference into one day, borrowing from or carrying into the days.
  // Out-of-range times can need two borrows.
  logic signed [T2W-1:0]    t_ext, t_plus1, t_plus2;
  logic signed [DnormW-1:0] d_ext;
  logic signed [DnormW-1:0] dnorm_next;
  logic [RemW-1:0]          tnorm_next;
  logic signed [DnormW-1:0] dnorm5;
  logic [RemW-1:0]          tnorm5;

  always_comb begin
    t_ext   = T2W'(tdiff4);
    d_ext   = DnormW'(ddiff4);
    t_plus1 = t_ext + signed'(T2W'(SecsPerDay));
    t_plus2 = t_ext + signed'(T2W'(2 * SecsPerDay));
    if (t_ext >= signed'(T2W'(SecsPerDay))) begin
      tnorm_next = RemW'(t_ext - signed'(T2W'(SecsPerDay)));
      dnorm_next = d_ext + signed'(DnormW'(1));
    end else if (t_ext >= signed'(T2W'(0))) begin
      tnorm_next = RemW'(t_ext);
      dnorm_next = d_ext;
    end else if (t_plus1 >= signed'(T2W'(0))) begin
      tnorm_next = RemW'(t_plus1);
      dnorm_next = d_ext - signed'(DnormW'(1));
    end else begin
      tnorm_next = RemW'(t_plus2);
      dnorm_next = d_ext - signed'(DnormW'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      dnorm5 <= dnorm_next;
      tnorm5 <= tnorm_next;
    end
  end

  // Stage 6: absolute value of days * 86400 + seconds.
  logic [DaysOutW-1:0] days6;
  logic [RemW-1:0]     rem6;
  logic [DnormW-1:0]   dneg;

  assign dneg = DnormW'(-dnorm5);

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      if (dnorm5 >= signed'(DnormW'(0))) begin
        days6 <= DaysOutW'(dnorm5);
        rem6  <= tnorm5;
      end else if (tnorm5 == '0) begin
        days6 <= DaysOutW'(dneg);
        rem6  <= '0;
      end else begin
        days6 <= DaysOutW'(dneg - DnormW'(1));
        rem6  <= RemW'(SecsPerDay) - tnorm5;
      end
    end
  end

  // Stage 7: hours.
  logic [DaysOutW-1:0] days7;
  logic [RemW-1:0]     rem7;
  logic [HourW-1:0]    hours7;
  logic [ProdHW-1:0]   hprod;

  assign hprod = ProdHW'(rem6) * ProdHW'(RecipHour);

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      days7  <= days6;
      rem7   <= rem6;
      hours7 <= HourW'(hprod >> ShiftHour);
    end
  end

  // Stage 8: seconds within the hour.
  logic [DaysOutW-1:0] days8;
  logic [HourW-1:0]    hours8;
  logic [MinW-1:0]     rsec8;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      days8  <= days7;
      hours8 <= hours7;
      rsec8  <= MinW'(rem7 - RemW'(hours7) * RemW'(SecsPerHour));
    end
  end

  // Stage 9: minutes.
  logic [DaysOutW-1:0] days9;
  logic [HourW-1:0]    hours9;
  logic [MinW-1:0]     rsec9;
  logic [MinuteW-1:0]  mins9;
  logic [ProdMW-1:0]   mprod;

  assign mprod = ProdMW'(rsec8) * ProdMW'(RecipMin);

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      days9  <= days8;
      hours9 <= hours8;
      rsec9  <= rsec8;
      mins9  <= MinuteW'(mprod >> ShiftMin);
    end
  end

  // Stage 10: output register.
  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      rsp.elapsed_days    <= days9;
      rsp.elapsed_hours   <= hours9;
      rsp.elapsed_minutes <= mins9;
      rsp.elapsed_seconds <= SecondW'(rsec9 - MinW'(mins9) * MinW'(SecsPerMin));
    end
  end

  assign rsp.valid = vld[NStage];

`ifndef SYNTH
  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.elapsed_hours < HourW'(24)) && (rsp.elapsed_minutes < MinuteW'(60))
                  && (rsp.elapsed_seconds < SecondW'(60)))
    else $error("elapsed time of day out of range");

  a_borrow_done: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (tnorm5 < RemW'(SecsPerDay)))
    else $error("second difference not normalised into one day");

  a_open_when_drained: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready)
    else $error("input held off while the output stage is empty");
`endif

endmodule

`default_nettype wire
